### hw/rtl/psfr_pkg.sv
package psfr_pkg;

  // Frame layout
  localparam int unsigned FRAME_BYTES = 10;
  localparam int unsigned CNT_W       = 4;

  localparam logic [CNT_W-1:0] IDX_CMD      = CNT_W'(1);
  localparam logic [CNT_W-1:0] IDX_FIRST    = CNT_W'(2);
  localparam logic [CNT_W-1:0] IDX_LAST_SUM = CNT_W'(FRAME_BYTES - 3);
  localparam logic [CNT_W-1:0] IDX_CHECK    = CNT_W'(FRAME_BYTES - 2);
  localparam logic [CNT_W-1:0] IDX_TAIL     = CNT_W'(FRAME_BYTES - 1);

  localparam logic [7:0] HEAD_BYTE = 8'hAA;
  localparam logic [7:0] TAIL_BYTE = 8'hAB;

  localparam logic [13:0] PERIOD_MIN_SEC = 14'd60;
  localparam logic [13:0] PERIOD_CONT    = 14'd1;

  // Settings reply types (byte 2)
  localparam logic [7:0] SET_REPORTING = 8'd2;
  localparam logic [7:0] SET_ID        = 8'd5;
  localparam logic [7:0] SET_WORK      = 8'd6;
  localparam logic [7:0] SET_FIRMWARE  = 8'd7;
  localparam logic [7:0] SET_PERIOD    = 8'd8;

  // Frame kinds
  localparam logic [1:0] KIND_DATA     = 2'd0;
  localparam logic [1:0] KIND_DATA100  = 2'd1;
  localparam logic [1:0] KIND_SETTINGS = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_INIT_ID       = 2'd0;
  localparam logic [1:0] CFG_DATA_CODE     = 2'd1;
  localparam logic [1:0] CFG_SETTINGS_CODE = 2'd2;
  localparam logic [1:0] CFG_DATA100_CODE  = 2'd3;

  typedef struct packed {
    logic [1:0]  frame_kind;
    logic [15:0] pm25_tenths;
    logic [15:0] pm10_tenths;
    logic [15:0] pm100_value;
    logic        reporting_active;
    logic [15:0] sensor_ident;
    logic        work_awake;
    logic [13:0] period_seconds;
    logic [7:0]  firmware_year;
    logic [7:0]  firmware_month;
    logic [7:0]  firmware_day;
  } result_t;

endpackage

### hw/rtl/psfr_result_buf.sv
module psfr_result_buf import psfr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_data_i,
  output logic    space_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_data_o
);

  // Output register plus one skid slot; skid only fills while the head stalls.
  logic    head_valid_q, head_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t head_q, head_d;
  result_t skid_q, skid_d;
  logic    pop;

  assign pop     = head_valid_q && out_ready_i;
  assign space_o = !skid_valid_q;

  always_comb begin
    head_valid_d = head_valid_q;
    skid_valid_d = skid_valid_q;
    head_d       = head_q;
    skid_d       = skid_q;
    if (!head_valid_q) begin
      head_valid_d = push_i;
      head_d       = push_data_i;
    end else if (pop) begin
      if (skid_valid_q) begin
        head_d       = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        head_valid_d = push_i;
        head_d       = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign out_valid_o = head_valid_q;
  assign out_data_o  = head_q;

endmodule

### hw/rtl/particulate_sensor_frame_receiver.sv
// A result enters the output buffer when its tail byte is accepted.
// Throughput: one byte per cycle unless stalled; at most one result per 10-byte frame.
// A two-entry output buffer lets bytes keep flowing while a result waits; the input
// stalls only when both entries are full.
// Reset (rst_ni, async, active low): parser hunts for a head, held values clear,
// configuration returns to id 0xFFFF and codes 0xC0 / 0xC5 / 0xCF.
module particulate_sensor_frame_receiver import psfr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  // received byte requests
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  rx_byte_i,
  // decoded result requests
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  frame_kind_o,
  output logic [15:0] pm25_tenths_o,
  output logic [15:0] pm10_tenths_o,
  output logic [15:0] pm100_value_o,
  output logic        reporting_active_o,
  output logic [15:0] sensor_ident_o,
  output logic        work_awake_o,
  output logic [13:0] period_seconds_o,
  output logic [7:0]  firmware_year_o,
  output logic [7:0]  firmware_month_o,
  output logic [7:0]  firmware_day_o
);

  // Parser phases
  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_CMD  = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_TAIL = 2'd3;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] init_id_q;
  logic [7:0]  data_code_q;
  logic [7:0]  settings_code_q;
  logic [7:0]  data100_code_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_id_q       <= 16'hFFFF;
      data_code_q     <= 8'hC0;
      settings_code_q <= 8'hC5;
      data100_code_q  <= 8'hCF;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INIT_ID:       init_id_q       <= cfg_wdata_i;
        CFG_DATA_CODE:     data_code_q     <= cfg_wdata_i[7:0];
        CFG_SETTINGS_CODE: settings_code_q <= cfg_wdata_i[7:0];
        CFG_DATA100_CODE:  data100_code_q  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Parser state and frame bytes
  // ---------------------------------------------------------------------------
  logic [1:0]       phase_q, phase_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [7:0]       sum_q, sum_d;      // running sum of data bytes 2..7
  logic [7:0]       frame_q [1:FRAME_BYTES-2];
  logic             store_en;
  logic [CNT_W-1:0] store_idx;

  // Held decoded values
  logic [15:0] pm25_q, pm25_d;
  logic [15:0] pm10_q, pm10_d;
  logic [15:0] pm100_q, pm100_d;
  logic        report_q, report_d;
  logic [15:0] ident_q, ident_d;
  logic        id_seen_q, id_seen_d;
  logic        awake_q, awake_d;
  logic [13:0] period_q, period_d;
  logic [7:0]  fw_year_q, fw_year_d;
  logic [7:0]  fw_month_q, fw_month_d;
  logic [7:0]  fw_day_q, fw_day_d;

  logic        accept;
  logic [7:0]  b;
  logic        code_known;
  logic        frame_good;
  logic [13:0] period_mul;
  logic        res_push;
  logic [1:0]  res_kind;
  result_t     res;

  assign accept     = in_valid_i && in_ready_o;
  assign b          = rx_byte_i;
  assign code_known = (b == settings_code_q) || (b == data_code_q) || (b == data100_code_q);
  assign frame_good = (b == TAIL_BYTE) && (sum_q == frame_q[IDX_CHECK]);
  // minutes to seconds; byte 4 of a period reply
  assign period_mul = 14'(frame_q[4]) * PERIOD_MIN_SEC;

  always_comb begin
    phase_d    = phase_q;
    count_d    = count_q;
    sum_d      = sum_q;
    store_en   = 1'b0;
    store_idx  = count_q;
    pm25_d     = pm25_q;
    pm10_d     = pm10_q;
    pm100_d    = pm100_q;
    report_d   = report_q;
    ident_d    = ident_q;
    id_seen_d  = id_seen_q;
    awake_d    = awake_q;
    period_d   = period_q;
    fw_year_d  = fw_year_q;
    fw_month_d = fw_month_q;
    fw_day_d   = fw_day_q;
    res_push   = 1'b0;
    res_kind   = KIND_DATA;

    if (accept) begin
      case (phase_q)
        PH_WAIT: begin
          if (b == HEAD_BYTE) begin
            count_d = IDX_CMD;
            phase_d = PH_CMD;
          end
        end
        PH_CMD: begin
          // an unknown id is dropped, not retried as a head
          if (!code_known) begin
            phase_d = PH_WAIT;
          end else begin
            store_en  = 1'b1;
            store_idx = IDX_CMD;
            count_d   = IDX_FIRST;
            sum_d     = 8'd0;
            phase_d   = PH_DATA;
          end
        end
        PH_DATA: begin
          store_en = 1'b1;
          count_d  = count_q + 1'b1;
          if (count_q <= IDX_LAST_SUM) begin
            sum_d = sum_q + b;
          end
          if (count_q == IDX_CHECK) begin
            phase_d = PH_TAIL;
          end
        end
        PH_TAIL: begin
          count_d = '0;
          phase_d = PH_WAIT;
          if (frame_good) begin
            res_push = 1'b1;
            // settings beats data, data beats data100 when codes collide
            if (frame_q[IDX_CMD] == settings_code_q) begin
              res_kind = KIND_SETTINGS;
              case (frame_q[2])
                SET_REPORTING: report_d = (frame_q[4] != 8'd0);
                SET_ID: begin
                  ident_d   = {frame_q[6], frame_q[7]};
                  id_seen_d = 1'b1;
                end
                SET_WORK:      awake_d = (frame_q[4] != 8'd0);
                SET_PERIOD:    period_d = (frame_q[4] == 8'd0) ? PERIOD_CONT : period_mul;
                SET_FIRMWARE: begin
                  fw_year_d  = frame_q[3];
                  fw_month_d = frame_q[4];
                  fw_day_d   = frame_q[5];
                end
                default: ;
              endcase
            end else if (frame_q[IDX_CMD] == data_code_q) begin
              res_kind = KIND_DATA;
              pm25_d   = {frame_q[3], frame_q[2]};
              pm10_d   = {frame_q[5], frame_q[4]};
            end else begin
              res_kind = KIND_DATA100;
              pm100_d  = {frame_q[5], frame_q[4]};
            end
          end
        end
        default: phase_d = PH_WAIT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_WAIT;
      count_q    <= '0;
      sum_q      <= 8'd0;
      pm25_q     <= 16'd0;
      pm10_q     <= 16'd0;
      pm100_q    <= 16'd0;
      report_q   <= 1'b0;
      ident_q    <= 16'hFFFF;
      id_seen_q  <= 1'b0;
      awake_q    <= 1'b0;
      period_q   <= 14'd0;
      fw_year_q  <= 8'd0;
      fw_month_q <= 8'd0;
      fw_day_q   <= 8'd0;
    end else begin
      phase_q    <= phase_d;
      count_q    <= count_d;
      sum_q      <= sum_d;
      pm25_q     <= pm25_d;
      pm10_q     <= pm10_d;
      pm100_q    <= pm100_d;
      report_q   <= report_d;
      ident_q    <= ident_d;
      id_seen_q  <= id_seen_d;
      awake_q    <= awake_d;
      period_q   <= period_d;
      fw_year_q  <= fw_year_d;
      fw_month_q <= fw_month_d;
      fw_day_q   <= fw_day_d;
    end
  end

  // Frame bytes: command to check byte, always written before being read within a frame
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      frame_q[store_idx] <= b;
    end
  end

  // ---------------------------------------------------------------------------
  // Result assembly and output buffer
  // ---------------------------------------------------------------------------
  always_comb begin
    res.frame_kind       = res_kind;
    res.pm25_tenths      = pm25_d;
    res.pm10_tenths      = pm10_d;
    res.pm100_value      = pm100_d;
    res.reporting_active = report_d;
    // until an id reply arrives the configured id is reported
    res.sensor_ident     = id_seen_d ? ident_d : init_id_q;
    res.work_awake       = awake_d;
    res.period_seconds   = period_d;
    res.firmware_year    = fw_year_d;
    res.firmware_month   = fw_month_d;
    res.firmware_day     = fw_day_d;
  end

  result_t out_res;

  psfr_result_buf u_result_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .push_data_i (res),
    .space_o     (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_res)
  );

  assign frame_kind_o       = out_res.frame_kind;
  assign pm25_tenths_o      = out_res.pm25_tenths;
  assign pm10_tenths_o      = out_res.pm10_tenths;
  assign pm100_value_o      = out_res.pm100_value;
  assign reporting_active_o = out_res.reporting_active;
  assign sensor_ident_o     = out_res.sensor_ident;
  assign work_awake_o       = out_res.work_awake;
  assign period_seconds_o   = out_res.period_seconds;
  assign firmware_year_o    = out_res.firmware_year;
  assign firmware_month_o   = out_res.firmware_month;
  assign firmware_day_o     = out_res.firmware_day;

endmodule
